### hw/rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types, register indexes and widths for the compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MUL_W = 33;
	localparam int DIV_W = 32;
	localparam int RAW_W = 24;
	localparam int TEMP_W = 16;
	localparam int PRES_W = 18;

	localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B1_B2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MC_MD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OSS = 3'd5;

	localparam logic OP_TEMP = 1'b0;
	localparam logic OP_PRES = 1'b1;

	typedef struct packed {
		logic [31:0] ac1_ac2;
		logic [31:0] ac3_ac4;
		logic [31:0] ac5_ac6;
		logic [31:0] b1_b2;
		logic [31:0] mc_md;
		logic [1:0]  oss;
	} cfg_t;

	typedef struct packed {
		logic                     kind;
		logic signed [TEMP_W-1:0] temp;
		logic [PRES_W-1:0]        pres;
		logic                     fault;
	} res_t;

endpackage

### hw/rtl/bpc_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, shared by all product terms.
// ----------------------------------------------------------------------------
module bpc_mul
	import bpc_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_W-1:0]   a,
	input  logic signed [MUL_W-1:0]   b,
	output logic signed [2*MUL_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

### hw/rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpc_div
	import bpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done_q,
	output logic [DIV_W-1:0] quo_q
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W+1:0] diff;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff = {1'b0, shifted} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[DIV_W+1]) begin
				rem_q <= diff[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

endmodule

### hw/rtl/bpc_core.sv
// ----------------------------------------------------------------------------
// Compensation sequencer
// Steps one item through the compensation formulas on the shared multiplier
// and divider, and holds the result until the output register takes it.
// ----------------------------------------------------------------------------
module bpc_core
	import bpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             op,
	input  logic [RAW_W-1:0] raw,
	input  cfg_t             cfg,
	input  logic             res_take,
	output logic             idle,
	output logic             res_valid,
	output res_t             res
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_X1M = 5'd1;
	localparam logic [4:0] ST_X1W = 5'd2;
	localparam logic [4:0] ST_DEN = 5'd3;
	localparam logic [4:0] ST_BDIV = 5'd4;
	localparam logic [4:0] ST_TEMP = 5'd5;
	localparam logic [4:0] ST_B6 = 5'd6;
	localparam logic [4:0] ST_SQ = 5'd7;
	localparam logic [4:0] ST_X2 = 5'd8;
	localparam logic [4:0] ST_B2L = 5'd9;
	localparam logic [4:0] ST_B2H = 5'd10;
	localparam logic [4:0] ST_X1C = 5'd11;
	localparam logic [4:0] ST_B1L = 5'd12;
	localparam logic [4:0] ST_B1H = 5'd13;
	localparam logic [4:0] ST_B3A = 5'd14;
	localparam logic [4:0] ST_B3B = 5'd15;
	localparam logic [4:0] ST_B4M = 5'd16;
	localparam logic [4:0] ST_B4W = 5'd17;
	localparam logic [4:0] ST_B7W = 5'd18;
	localparam logic [4:0] ST_PST = 5'd19;
	localparam logic [4:0] ST_PDIV = 5'd20;
	localparam logic [4:0] ST_PPM = 5'd21;
	localparam logic [4:0] ST_Y2 = 5'd22;
	localparam logic [4:0] ST_Y1L = 5'd23;
	localparam logic [4:0] ST_Y1H = 5'd24;
	localparam logic [4:0] ST_Y1W = 5'd25;
	localparam logic [4:0] ST_PS = 5'd26;
	localparam logic [4:0] ST_PF = 5'd27;
	localparam logic [4:0] ST_DONE = 5'd28;

	localparam logic signed [63:0] TEMP_MAX = 64'sd32767;
	localparam logic signed [63:0] TEMP_MIN = -64'sd32768;
	localparam logic signed [63:0] PRES_MAX = 64'sd262143;

	function automatic logic signed [63:0] div4(input logic signed [63:0] v);
		logic signed [63:0] adj;
		adj = v[63] ? v + 64'sd3 : v;
		return adj >>> 2;
	endfunction

	function automatic logic signed [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	logic [4:0]               state_q;
	logic                     op_q;
	logic [15:0]              ut_q;
	logic [RAW_W-1:0]         up_q;
	logic signed [63:0]       x1_q, b5_q, b6_q, sq6_q, x2_q, acc_q;
	logic signed [63:0]       xa_q, xb_q, xc_q, vb_q, b3_q, x3_q;
	logic [16:0]              b4_q;
	logic [31:0]              b7_q, p_q;
	logic [47:0]              sq_q;
	logic signed [63:0]       y1_q, y2_q, s_q;
	logic                     neg_q;
	res_t                     res_q;

	logic signed [63:0]       ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic signed [63:0]       ma, mb, prod, den, mcs, quot_s, t_val, p_val;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod_q;
	logic                     div_start, div_done;
	logic [DIV_W-1:0]         div_n, div_d, div_quo;
	logic [31:0]              x3u, upb3, c50k;

	assign ac1 = sx16(cfg.ac1_ac2[31:16]);
	assign ac2 = sx16(cfg.ac1_ac2[15:0]);
	assign ac3 = sx16(cfg.ac3_ac4[31:16]);
	assign ac4 = {48'b0, cfg.ac3_ac4[15:0]};
	assign ac5 = {48'b0, cfg.ac5_ac6[31:16]};
	assign ac6 = {48'b0, cfg.ac5_ac6[15:0]};
	assign b1 = sx16(cfg.b1_b2[31:16]);
	assign b2 = sx16(cfg.b1_b2[15:0]);
	assign mc = sx16(cfg.mc_md[31:16]);
	assign md = sx16(cfg.mc_md[15:0]);

	assign prod = prod_q[63:0];
	assign den = x1_q + md;
	assign mcs = mc <<< 11;
	assign x3u = 32'(x3_q + 64'sd32768);
	assign upb3 = {8'b0, up_q} - b3_q[31:0];
	assign c50k = 32'd50000 >> cfg.oss;
	assign quot_s = neg_q ? -$signed({32'b0, div_quo}) : $signed({32'b0, div_quo});
	assign t_val = (b5_q + 64'sd8) >>> 4;
	assign p_val = $signed({32'b0, p_q}) + (s_q >>> 4);

	always_comb begin
		unique case (state_q)
			ST_X1M: begin
				ma = $signed({48'b0, ut_q}) - ac6;
				mb = ac5;
			end
			ST_SQ: begin
				ma = b6_q;
				mb = b6_q;
			end
			ST_X2: begin
				ma = ac2;
				mb = b6_q;
			end
			ST_B2L: begin
				ma = b2;
				mb = {40'b0, sq6_q[23:0]};
			end
			ST_B2H: begin
				ma = b2;
				mb = {40'b0, sq6_q[47:24]};
			end
			ST_X1C: begin
				ma = ac3;
				mb = b6_q;
			end
			ST_B1L: begin
				ma = b1;
				mb = {40'b0, sq6_q[23:0]};
			end
			ST_B1H: begin
				ma = b1;
				mb = {40'b0, sq6_q[47:24]};
			end
			ST_B4M: begin
				ma = ac4;
				mb = {32'b0, x3u};
			end
			ST_B4W: begin
				ma = {32'b0, upb3};
				mb = {32'b0, c50k};
			end
			ST_PPM: begin
				ma = {32'b0, p_q};
				mb = {32'b0, p_q};
			end
			ST_Y2: begin
				ma = -64'sd7357;
				mb = {32'b0, p_q};
			end
			ST_Y1L: begin
				ma = 64'sd3038;
				mb = {40'b0, sq_q[23:0]};
			end
			ST_Y1H: begin
				ma = 64'sd3038;
				mb = {40'b0, sq_q[47:24]};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mul_a = ma[MUL_W-1:0];
	assign mul_b = mb[MUL_W-1:0];

	always_comb begin
		div_start = 1'b0;
		div_n = '0;
		div_d = '0;
		if (state_q == ST_DEN) begin
			div_start = (den != '0);
			div_n = mcs[63] ? 32'(-mcs) : mcs[31:0];
			div_d = den[63] ? 32'(-den) : den[31:0];
		end else if (state_q == ST_PST) begin
			div_start = (b4_q != '0);
			div_n = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
			div_d = {15'b0, b4_q};
		end
	end

	bpc_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	bpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done_q   (div_done),
		.quo_q    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ut_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (op == OP_TEMP) begin
							ut_q <= raw[15:0];
						end
						state_q <= ST_X1M;
					end
				end
				ST_X1M: state_q <= ST_X1W;
				ST_X1W: state_q <= ST_DEN;
				ST_DEN: state_q <= (den == '0) ? ST_DONE : ST_BDIV;
				ST_BDIV: begin
					if (div_done) begin
						state_q <= (op_q == OP_PRES) ? ST_B6 : ST_TEMP;
					end
				end
				ST_TEMP: state_q <= ST_DONE;
				ST_B6: state_q <= ST_SQ;
				ST_SQ: state_q <= ST_X2;
				ST_X2: state_q <= ST_B2L;
				ST_B2L: state_q <= ST_B2H;
				ST_B2H: state_q <= ST_X1C;
				ST_X1C: state_q <= ST_B1L;
				ST_B1L: state_q <= ST_B1H;
				ST_B1H: state_q <= ST_B3A;
				ST_B3A: state_q <= ST_B3B;
				ST_B3B: state_q <= ST_B4M;
				ST_B4M: state_q <= ST_B4W;
				ST_B4W: state_q <= ST_B7W;
				ST_B7W: state_q <= ST_PST;
				ST_PST: state_q <= (b4_q == '0) ? ST_DONE : ST_PDIV;
				ST_PDIV: begin
					if (div_done) begin
						state_q <= ST_PPM;
					end
				end
				ST_PPM: state_q <= ST_Y2;
				ST_Y2: state_q <= ST_Y1L;
				ST_Y1L: state_q <= ST_Y1H;
				ST_Y1H: state_q <= ST_Y1W;
				ST_Y1W: state_q <= ST_PS;
				ST_PS: state_q <= ST_PF;
				ST_PF: state_q <= ST_DONE;
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q <= op;
				up_q <= raw >> (4'd8 - {2'b00, cfg.oss});
				res_q <= res_t'{kind: op, temp: '0, pres: '0, fault: 1'b0};
			end
			ST_X1W: x1_q <= prod >>> 15;
			ST_DEN: begin
				neg_q <= mcs[63] ^ den[63];
				if (den == '0) begin
					res_q.fault <= 1'b1;
					if (op_q == OP_PRES) begin
						res_q.pres <= '1;
					end else begin
						res_q.temp <= TEMP_W'(TEMP_MAX);
					end
				end
			end
			ST_BDIV: b5_q <= x1_q + quot_s;
			ST_TEMP: begin
				if (t_val > TEMP_MAX) begin
					res_q.temp <= TEMP_W'(TEMP_MAX);
					res_q.fault <= 1'b1;
				end else if (t_val < TEMP_MIN) begin
					res_q.temp <= TEMP_W'(TEMP_MIN);
					res_q.fault <= 1'b1;
				end else begin
					res_q.temp <= t_val[TEMP_W-1:0];
				end
			end
			ST_B6: b6_q <= b5_q - 64'sd4000;
			ST_X2: sq6_q <= prod >>> 12;
			ST_B2L: x2_q <= prod >>> 11;
			ST_B2H: acc_q <= prod;
			ST_X1C: xa_q <= (acc_q + (prod <<< 24)) >>> 11;
			ST_B1L: xb_q <= prod >>> 13;
			ST_B1H: acc_q <= prod;
			ST_B3A: begin
				xc_q <= (acc_q + (prod <<< 24)) >>> 16;
				vb_q <= ((ac1 <<< 2) + xa_q + x2_q) <<< cfg.oss;
			end
			ST_B3B: begin
				b3_q <= div4(vb_q + 64'sd2);
				x3_q <= div4(xb_q + xc_q + 64'sd2);
			end
			ST_B4W: b4_q <= prod[31:15];
			ST_B7W: b7_q <= prod[31:0];
			ST_PST: begin
				if (b4_q == '0) begin
					res_q.fault <= 1'b1;
					res_q.pres <= '1;
				end
			end
			ST_PDIV: p_q <= b7_q[31] ? {div_quo[30:0], 1'b0} : div_quo;
			ST_Y2: sq_q <= prod[63:16];
			ST_Y1L: y2_q <= prod >>> 16;
			ST_Y1H: acc_q <= prod;
			ST_Y1W: y1_q <= (acc_q + (prod <<< 24)) >>> 16;
			ST_PS: s_q <= y1_q + y2_q + 64'sd3791;
			ST_PF: begin
				if (p_val > PRES_MAX) begin
					res_q.pres <= '1;
					res_q.fault <= 1'b1;
				end else if (p_val < 0) begin
					res_q.pres <= '0;
					res_q.fault <= 1'b1;
				end else begin
					res_q.pres <= p_val[PRES_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign idle = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res = res_q;

endmodule

### hw/rtl/barometric_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// Barometric pressure compensation
// Turns raw barometer readings into calibrated temperature and pressure.
// ----------------------------------------------------------------------------
// Input items (operation, raw_reading) arrive on in_valid/in_stall; result
// items (kind, temperature_tenths, pressure_pascal, fault) leave on
// out_valid/out_stall. An item is taken when valid is high and stall is low.
// Calibration coefficients and the oversampling setting are written through
// cfg_we/cfg_index/cfg_data. The user must write them only while the block
// is idle; the block itself does not enforce this. One item is in work at a
// time. The sequencer steps each item through the shared multiplier and the
// bit-per-cycle divider, with two divisions for a pressure item and one for
// a temperature item. A zero divisor ends the item early. The next item is
// taken in the cycle after the result moves to the output register. A
// finished result waits in the sequencer while the receiver stalls with the
// output register full.
// Reset clears the calibration registers, the stored raw temperature and
// all valids.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_top
	import bpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     operation,
	input  logic [RAW_W-1:0]         raw_reading,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     kind,
	output logic signed [TEMP_W-1:0] temperature_tenths,
	output logic [PRES_W-1:0]        pressure_pascal,
	output logic                     fault,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	cfg_t cfg_q;
	res_t res, out_q;
	logic idle, res_valid, res_take, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AC1_AC2: cfg_q.ac1_ac2 <= cfg_data;
				REG_AC3_AC4: cfg_q.ac3_ac4 <= cfg_data;
				REG_AC5_AC6: cfg_q.ac5_ac6 <= cfg_data;
				REG_B1_B2: cfg_q.b1_b2 <= cfg_data;
				REG_MC_MD: cfg_q.mc_md <= cfg_data;
				REG_OSS: cfg_q.oss <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	bpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && idle),
		.op        (operation),
		.raw       (raw_reading),
		.cfg       (cfg_q),
		.res_take  (res_take),
		.idle      (idle),
		.res_valid (res_valid),
		.res       (res)
	);

	assign res_take = res_valid && (!out_valid_q || !out_stall);
	assign in_stall = !idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = out_q.kind;
	assign temperature_tenths = out_q.temp;
	assign pressure_pascal = out_q.pres;
	assign fault = out_q.fault;

endmodule

### tb/tb_barometric_pressure_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric pressure compensation testbench
// Drives temperature and pressure items through the block under several
// calibration settings and idle patterns. It predicts every result with an
// integer model of the compensation and checks each result item field by
// field, in order.
// ----------------------------------------------------------------------------
module tb_barometric_pressure_compensation_top;
	import bpc_pkg::*;

	typedef struct {
		logic        op;
		logic [23:0] raw;
	} reading_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     operation = 1'b0;
	logic [RAW_W-1:0]         raw_reading = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     kind;
	logic signed [TEMP_W-1:0] temperature_tenths;
	logic [PRES_W-1:0]        pressure_pascal;
	logic                     fault;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	reading_t    readings_q[$];
	res_t        expected_q[$];
	bit [31:0]   cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;
	bit [1:0]    cal_oss;
	bit [15:0]   stored_ut;
	int          send_idle, recv_idle;
	bit          hold_off;
	bit          taken;
	int          mismatches;

	barometric_pressure_compensation_top dut (.*);

	always #4 clk = ~clk;

	function automatic res_t compensate(input logic op, input logic [23:0] raw);
		longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		longint x1, x2, x3, den, b5, b6, sq6, b3, p, y1, y2, t, pr;
		bit [31:0] b4, b7, p32, up, t32;
		bit [63:0] sq, w;
		int oss;
		bit ok;
		res_t r;
		r = '0;
		r.kind = op;
		b5 = 0;
		if (op == OP_TEMP)
			stored_ut = raw[15:0];
		ac5 = cal_ac5_ac6[31:16];
		ac6 = cal_ac5_ac6[15:0];
		mc = longint'($signed(cal_mc_md[31:16]));
		md = longint'($signed(cal_mc_md[15:0]));
		x1 = ((longint'(stored_ut) - ac6) * ac5) >>> 15;
		den = x1 + md;
		ok = (den != 0);
		if (ok)
			b5 = x1 + (mc * 2048) / den;
		if (op == OP_TEMP) begin
			if (!ok) begin
				r.fault = 1'b1;
				t = 32767;
			end else begin
				t = (b5 + 8) >>> 4;
				if (t > 32767) begin
					t = 32767;
					r.fault = 1'b1;
				end
				if (t < -32768) begin
					t = -32768;
					r.fault = 1'b1;
				end
			end
			r.temp = t[15:0];
		end else begin
			oss = cal_oss;
			up = raw >> (8 - oss);
			if (!ok) begin
				r.fault = 1'b1;
				pr = 262143;
			end else begin
				ac1 = longint'($signed(cal_ac1_ac2[31:16]));
				ac2 = longint'($signed(cal_ac1_ac2[15:0]));
				ac3 = longint'($signed(cal_ac3_ac4[31:16]));
				ac4 = cal_ac3_ac4[15:0];
				b1 = longint'($signed(cal_b1_b2[31:16]));
				b2 = longint'($signed(cal_b1_b2[15:0]));
				b6 = b5 - 4000;
				sq6 = (b6 * b6) >>> 12;
				x1 = (b2 * sq6) >>> 11;
				x2 = (ac2 * b6) >>> 11;
				x3 = x1 + x2;
				b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
				x1 = (ac3 * b6) >>> 13;
				x2 = (b1 * sq6) >>> 16;
				x3 = (x1 + x2 + 2) / 4;
				t32 = 32'(x3 + 32768);
				w = cal_ac3_ac4[15:0] * t32;
				b4 = w[31:0] >> 15;
				t32 = up - 32'(b3);
				w = t32 * (32'd50000 >> oss);
				b7 = w[31:0];
				if (b4 == 0) begin
					r.fault = 1'b1;
					pr = 262143;
				end else begin
					if (b7 < 32'h8000_0000)
						p32 = (b7 * 2) / b4;
					else
						p32 = (b7 / b4) * 2;
					p = longint'(p32);
					sq = (64'(p32) * 64'(p32)) >> 16;
					y1 = longint'((sq * 3038) >> 16);
					y2 = (-7357 * p) >>> 16;
					pr = p + ((y1 + y2 + 3791) >>> 4);
					if (pr > 262143) begin
						pr = 262143;
						r.fault = 1'b1;
					end
					if (pr < 0) begin
						pr = 0;
						r.fault = 1'b1;
					end
				end
			end
			r.pres = pr[17:0];
		end
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_AC1_AC2: cal_ac1_ac2 = val;
			REG_AC3_AC4: cal_ac3_ac4 = val;
			REG_AC5_AC6: cal_ac5_ac6 = val;
			REG_B1_B2: cal_b1_b2 = val;
			REG_MC_MD: cal_mc_md = val;
			REG_OSS: cal_oss = val[1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (readings_q.size() != 0 || in_valid || expected_q.size() != 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic load_cal(input logic [31:0] a, b, c, d, e, input logic [1:0] o);
		write_reg(REG_AC1_AC2, a);
		write_reg(REG_AC3_AC4, b);
		write_reg(REG_AC5_AC6, c);
		write_reg(REG_B1_B2, d);
		write_reg(REG_MC_MD, e);
		write_reg(REG_OSS, {30'b0, o});
	endtask

	task automatic push(input logic op, input logic [23:0] raw);
		reading_t it;
		it.op = op;
		it.raw = raw;
		readings_q.push_back(it);
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 20)
				push(OP_TEMP, 24'($urandom_range(26000, 30000)) | 24'($urandom() & 32'hFF0000));
			else
				push(1'($urandom_range(1)), 24'($urandom()));
		end
	endtask

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_q.push_back(compensate(operation, raw_reading));
		end
		taken <= in_valid && !in_stall;
	end

	always @(negedge clk) begin
		reading_t it;
		if (arst_n && (!in_valid || taken)) begin
			if (hold_off || readings_q.size() == 0 || $urandom_range(99) < send_idle) begin
				in_valid <= 1'b0;
			end else begin
				it = readings_q.pop_front();
				in_valid <= 1'b1;
				operation <= it.op;
				raw_reading <= it.raw;
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		res_t e;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item: kind %0d", kind);
			end else begin
				e = expected_q.pop_front();
				if (kind !== e.kind || temperature_tenths !== e.temp
						|| pressure_pascal !== e.pres || fault !== e.fault) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
							e.kind, e.temp, e.pres, e.fault,
							kind, temperature_tenths, pressure_pascal, fault);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset calibration: pressure before any temperature, zero divisor.
		send_idle = 0;
		recv_idle = 0;
		push(OP_PRES, 24'hFFFFFF);
		push(OP_TEMP, 24'h000000);
		push(OP_PRES, 24'h000000);
		push(OP_TEMP, 24'hFFFFFF);
		wait_drained();

		// Typical sensor calibration with a known-good reading pair.
		load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
			{16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd0);
		write_reg(3'd6, 32'hFFFF_FFFF);
		write_reg(3'd7, 32'h0000_0000);
		push(OP_PRES, 24'd23843 << 8);
		push(OP_TEMP, 24'd27898);
		push(OP_PRES, 24'd23843 << 8);
		push(OP_PRES, 24'h000000);
		push(OP_PRES, 24'hFFFFFF);
		push(OP_TEMP, 24'h00FFFF);
		push(OP_TEMP, 24'h008000);
		push(OP_TEMP, 24'h000000);
		push(OP_PRES, 24'h800000);
		push(OP_TEMP, 24'hFF6CFA);
		push(OP_PRES, 24'h5D2300);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
					{16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd1);
				1: write_reg(REG_OSS, 32'd2);
				2: write_reg(REG_OSS, 32'hFFFF_FFFF);
				3: load_cal('1, '1, '1, '1, '1, 2'd3);
				4: load_cal(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0001,
					32'h7FFF_7FFF, 32'h8000_7FFF, 2'd0);
				5: load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd0},
					{16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd2);
				default: load_cal($urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), 2'($urandom_range(3)));
			endcase
			case (ph % 4)
				0: begin send_idle = 0; recv_idle = 0; end
				1: begin send_idle = 70; recv_idle = 0; end
				2: begin send_idle = 0; recv_idle = 70; end
				default: begin send_idle = 29; recv_idle = 29; end
			endcase
			push_random(55);
			if (ph == 2) begin
				do
					@(posedge clk);
				while (readings_q.size() != 0 || in_valid);
				hold_off = 1'b1;
				do
					@(posedge clk);
				while (expected_q.size() != 0);
				hold_off = 1'b0;
			end
			push_random(55);
			wait_drained();
		end

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_mul.sv
hw/rtl/bpc_div.sv
hw/rtl/bpc_core.sv
hw/rtl/barometric_pressure_compensation_top.sv
tb/tb_barometric_pressure_compensation_top.sv
